// ===== sv/stereo_drywet_volume_balance_mixer_defines.svh =====
`ifndef STEREO_DRYWET_VOLUME_BALANCE_MIXER_DEFINES_SVH
`define STEREO_DRYWET_VOLUME_BALANCE_MIXER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define SDVBM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdvbm check failed");

// next-cycle implication, sampled on clk, quiet in reset
`define SDVBM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdvbm check failed");

`endif

// ===== sv/sdvbm_pkg.sv =====
`default_nettype none

package sdvbm_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 15;

  localparam int OP_W   = SAMPLE_BITS + 2;
  localparam int COEF_W = GAIN_FRAC_BITS + 3;
  localparam int VAL_W  = SAMPLE_BITS + 3;
  localparam int ACC_W  = OP_W + COEF_W + 1;

  localparam int STAGE_W = 3;
  localparam int WET_W   = 16;
  localparam int VOL_W   = 16;
  localparam int BAL_W   = 17;

  localparam int STG_DRYWET  = 0;
  localparam int STG_VOLUME  = 1;
  localparam int STG_BALANCE = 2;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_ACTIVE    = 3'd0,
    REG_STAGE_EN  = 3'd1,
    REG_MONO      = 3'd2,
    REG_WET_GAIN  = 3'd3,
    REG_VOL_GAIN  = 3'd4,
    REG_BAL_LEFT  = 3'd5,
    REG_BAL_RIGHT = 3'd6
  } reg_idx_t;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_MUL_WET  = 10'b00_0000_0010,
    ST_MUL_DRY  = 10'b00_0000_0100,
    ST_DW_END   = 10'b00_0000_1000,
    ST_MUL_VOL  = 10'b00_0001_0000,
    ST_VOL_END  = 10'b00_0010_0000,
    ST_MUL_BAL0 = 10'b00_0100_0000,
    ST_MUL_BAL1 = 10'b00_1000_0000,
    ST_BAL_END  = 10'b01_0000_0000,
    ST_MERGE    = 10'b10_0000_0000
  } step_t;

  typedef struct packed {
    step_t step;
    logic  dw_en;
    logic  vol_en;
    logic  bal_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] dry_left;
    logic signed [SAMPLE_BITS-1:0] dry_right;
    logic signed [SAMPLE_BITS-1:0] wet_left;
    logic signed [SAMPLE_BITS-1:0] wet_right;
    logic                          block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mixed_left;
    logic signed [SAMPLE_BITS-1:0] mixed_right;
    logic                          peaks_valid;
    logic        [SAMPLE_BITS-1:0] in_peak_left;
    logic        [SAMPLE_BITS-1:0] in_peak_right;
    logic        [SAMPLE_BITS-1:0] out_peak_left;
    logic        [SAMPLE_BITS-1:0] out_peak_right;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/sdvbm_lane.sv =====
`default_nettype none

module sdvbm_lane (
  input  logic                                      clk,
  input  sdvbm_pkg::lane_ctrl_t                     ctrl,
  input  logic signed [sdvbm_pkg::SAMPLE_BITS-1:0]  wet,
  input  logic signed [sdvbm_pkg::SAMPLE_BITS-1:0]  dry,
  input  logic signed [sdvbm_pkg::COEF_W-1:0]       gain_wet,
  input  logic signed [sdvbm_pkg::COEF_W-1:0]       gain_dry,
  input  logic signed [sdvbm_pkg::COEF_W-1:0]       gain_vol,
  input  logic signed [sdvbm_pkg::COEF_W-1:0]       coef_own,
  input  logic signed [sdvbm_pkg::COEF_W-1:0]       coef_other,
  input  logic signed [sdvbm_pkg::VAL_W-1:0]        other_val,
  output logic signed [sdvbm_pkg::VAL_W-1:0]        val
);

  localparam int OP_W   = sdvbm_pkg::OP_W;
  localparam int COEF_W = sdvbm_pkg::COEF_W;
  localparam int VAL_W  = sdvbm_pkg::VAL_W;
  localparam int ACC_W  = sdvbm_pkg::ACC_W;
  localparam int GF     = sdvbm_pkg::GAIN_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF_G = ACC_W'(1) << (GF - 1);
  localparam logic signed [ACC_W-1:0] HALF_B = ACC_W'(1) << GF;

  logic signed [OP_W-1:0]        op_a;
  logic signed [COEF_W-1:0]      op_b;
  logic signed [OP_W+COEF_W-1:0] prod_full;
  logic signed [ACC_W-1:0]       prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [ACC_W-1:0]       add_a;
  logic signed [ACC_W-1:0]       sum;
  logic signed [ACC_W-1:0]       rnd_g;
  logic signed [ACC_W-1:0]       rnd_b;
  logic signed [VAL_W-1:0]       val_r;
  logic signed [VAL_W-1:0]       val_nxt;

  // shared multiplier operand select
  always_comb begin
    unique case (ctrl.step)
      sdvbm_pkg::ST_MUL_WET: begin
        op_a = OP_W'(wet);
        op_b = gain_wet;
      end
      sdvbm_pkg::ST_MUL_DRY: begin
        op_a = OP_W'(dry);
        op_b = gain_dry;
      end
      sdvbm_pkg::ST_MUL_VOL: begin
        op_a = $signed(val_r[OP_W-1:0]);
        op_b = gain_vol;
      end
      sdvbm_pkg::ST_MUL_BAL0: begin
        op_a = $signed(val_r[OP_W-1:0]);
        op_b = coef_own;
      end
      sdvbm_pkg::ST_MUL_BAL1: begin
        op_a = $signed(other_val[OP_W-1:0]);
        op_b = coef_other;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_full = op_a * op_b;

  assign add_a = (ctrl.step == sdvbm_pkg::ST_VOL_END) ? HALF_G : acc_r;
  assign sum   = add_a + prod_r;
  assign rnd_g = sum >>> GF;
  assign rnd_b = sum >>> (GF + 1);

  always_comb begin
    acc_nxt = acc_r;
    val_nxt = val_r;
    unique case (ctrl.step)
      sdvbm_pkg::ST_MUL_DRY:  acc_nxt = prod_r + HALF_G;
      sdvbm_pkg::ST_MUL_BAL1: acc_nxt = prod_r + HALF_B;
      sdvbm_pkg::ST_DW_END:   val_nxt = ctrl.dw_en ? VAL_W'(rnd_g) : VAL_W'(wet);
      sdvbm_pkg::ST_VOL_END:  val_nxt = ctrl.vol_en ? VAL_W'(rnd_g) : val_r;
      sdvbm_pkg::ST_BAL_END:  val_nxt = ctrl.bal_en ? VAL_W'(rnd_b) : val_r;
      default: begin
        acc_nxt = acc_r;
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ACC_W'(prod_full);
    acc_r  <= acc_nxt;
    val_r  <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

// ===== sv/sdvbm_merge.sv =====
`default_nettype none

module sdvbm_merge (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      load,
  input  logic                                      active,
  input  logic                                      mono,
  input  logic signed [sdvbm_pkg::VAL_W-1:0]        mix_left,
  input  logic signed [sdvbm_pkg::VAL_W-1:0]        mix_right,
  input  logic signed [sdvbm_pkg::SAMPLE_BITS-1:0]  dry_left,
  input  logic signed [sdvbm_pkg::SAMPLE_BITS-1:0]  dry_right,
  input  logic                                      block_end,
  input  logic                                      out_stall,
  output logic                                      out_valid,
  output sdvbm_pkg::out_item_t                      out_data,
  output logic                                      ready
);

  localparam int SB    = sdvbm_pkg::SAMPLE_BITS;
  localparam int VAL_W = sdvbm_pkg::VAL_W;

  localparam logic signed [VAL_W-1:0] S_MAX = VAL_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [VAL_W-1:0] S_MIN = -S_MAX - VAL_W'(1);

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [VAL_W-1:0] v);
    logic signed [SB-1:0] res;
    if (v > S_MAX) begin
      res = S_MAX[SB-1:0];
    end else if (v < S_MIN) begin
      res = S_MIN[SB-1:0];
    end else begin
      res = v[SB-1:0];
    end
    return res;
  endfunction

  function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] v);
    logic [SB-1:0] res;
    res = v[SB-1] ? SB'(-v) : SB'(v);
    return res;
  endfunction

  function automatic logic [SB-1:0] umax(input logic [SB-1:0] a, input logic [SB-1:0] b);
    logic [SB-1:0] res;
    res = (a > b) ? a : b;
    return res;
  endfunction

  logic                  out_valid_r;
  sdvbm_pkg::out_item_t  out_data_r;
  logic [SB-1:0]         ipk_l_r, ipk_r_r, opk_l_r, opk_r_r;
  logic [SB-1:0]         ipk_l_nxt, ipk_r_nxt, opk_l_nxt, opk_r_nxt;
  logic signed [SB-1:0]  left_s, right_s;

  assign ready = !out_valid_r || !out_stall;

  always_comb begin
    left_s    = active ? sat_sample(mix_left) : '0;
    right_s   = (active && !mono) ? sat_sample(mix_right) : '0;
    ipk_l_nxt = umax(ipk_l_r, mag(dry_left));
    ipk_r_nxt = mono ? ipk_r_r : umax(ipk_r_r, mag(dry_right));
    opk_l_nxt = active ? umax(opk_l_r, mag(left_s)) : opk_l_r;
    opk_r_nxt = active ? umax(opk_r_r, mag(right_s)) : opk_r_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ipk_l_r     <= '0;
      ipk_r_r     <= '0;
      opk_l_r     <= '0;
      opk_r_r     <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      ipk_l_r     <= block_end ? '0 : ipk_l_nxt;
      ipk_r_r     <= block_end ? '0 : ipk_r_nxt;
      opk_l_r     <= block_end ? '0 : opk_l_nxt;
      opk_r_r     <= block_end ? '0 : opk_r_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.mixed_left     <= left_s;
      out_data_r.mixed_right    <= right_s;
      out_data_r.peaks_valid    <= block_end;
      out_data_r.in_peak_left   <= block_end ? ipk_l_nxt : '0;
      out_data_r.in_peak_right  <= block_end ? ipk_r_nxt : '0;
      out_data_r.out_peak_left  <= block_end ? opk_l_nxt : '0;
      out_data_r.out_peak_right <= block_end ? opk_r_nxt : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/stereo_drywet_volume_balance_mixer.sv =====
// channel   dir   handshake              beat
// in_       in    in_valid / in_stall    dry and wet stereo frame, block end mark
// out_      out   out_valid / out_stall  mixed stereo frame, block peaks
// cfg       in    psel penable pwrite    seven control registers at 4*i
//
// one frame at a time, the next taken only back in idle: accept, eight steps through each lane's multiplier, merge
// the two lanes share one sequencer; balance reads the other lane's volume result
// the output register holds a finished beat so the next frame is taken meanwhile
// a stalled output holds the merge step until the register frees
// rst_n clears the sequencer, the peak meters and the registers to their defaults
`default_nettype none

module stereo_drywet_volume_balance_mixer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  sdvbm_pkg::in_item_t                   in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output sdvbm_pkg::out_item_t                  out_data,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sdvbm_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [sdvbm_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [sdvbm_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                  pready
);

  localparam int COEF_W = sdvbm_pkg::COEF_W;
  localparam int VAL_W  = sdvbm_pkg::VAL_W;
  localparam int DW     = sdvbm_pkg::CFG_DATA_W;
  localparam int AW     = sdvbm_pkg::CFG_ADDR_W;

  localparam logic signed [COEF_W-1:0] C_ONE = COEF_W'(1) << sdvbm_pkg::GAIN_FRAC_BITS;
  localparam logic signed [COEF_W-1:0] C_TWO = C_ONE <<< 1;

  logic                                   active_r;
  logic [sdvbm_pkg::STAGE_W-1:0]          stage_en_r;
  logic                                   mono_r;
  logic [sdvbm_pkg::WET_W-1:0]            wet_gain_r;
  logic [sdvbm_pkg::VOL_W-1:0]            vol_gain_r;
  logic signed [sdvbm_pkg::BAL_W-1:0]     bal_left_r;
  logic signed [sdvbm_pkg::BAL_W-1:0]     bal_right_r;

  sdvbm_pkg::reg_idx_t                    reg_idx;
  logic                                   wr_en;

  sdvbm_pkg::step_t                       state_r, state_nxt;
  sdvbm_pkg::in_item_t                    item_r;
  sdvbm_pkg::lane_ctrl_t                  lane_ctrl;

  logic signed [COEF_W-1:0]               wg, g, g_inv, vol;
  logic signed [COEF_W-1:0]               blx, brx, bl, br, pl, pr;
  logic signed [VAL_W-1:0]                val_left, val_right;
  logic                                   merge_ready, merge_load;

  assign reg_idx = sdvbm_pkg::reg_idx_t'(paddr[AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      stage_en_r  <= '0;
      mono_r      <= 1'b0;
      wet_gain_r  <= sdvbm_pkg::WET_W'(C_ONE);
      vol_gain_r  <= sdvbm_pkg::VOL_W'(C_ONE);
      bal_left_r  <= -sdvbm_pkg::BAL_W'(C_ONE);
      bal_right_r <= sdvbm_pkg::BAL_W'(C_ONE);
    end else if (wr_en) begin
      unique case (reg_idx)
        sdvbm_pkg::REG_ACTIVE:    active_r    <= pwdata[0];
        sdvbm_pkg::REG_STAGE_EN:  stage_en_r  <= pwdata[sdvbm_pkg::STAGE_W-1:0];
        sdvbm_pkg::REG_MONO:      mono_r      <= pwdata[0];
        sdvbm_pkg::REG_WET_GAIN:  wet_gain_r  <= pwdata[sdvbm_pkg::WET_W-1:0];
        sdvbm_pkg::REG_VOL_GAIN:  vol_gain_r  <= pwdata[sdvbm_pkg::VOL_W-1:0];
        sdvbm_pkg::REG_BAL_LEFT:  bal_left_r  <= $signed(pwdata[sdvbm_pkg::BAL_W-1:0]);
        sdvbm_pkg::REG_BAL_RIGHT: bal_right_r <= $signed(pwdata[sdvbm_pkg::BAL_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sdvbm_pkg::REG_ACTIVE:    prdata = DW'(active_r);
      sdvbm_pkg::REG_STAGE_EN:  prdata = DW'(stage_en_r);
      sdvbm_pkg::REG_MONO:      prdata = DW'(mono_r);
      sdvbm_pkg::REG_WET_GAIN:  prdata = DW'(wet_gain_r);
      sdvbm_pkg::REG_VOL_GAIN:  prdata = DW'(vol_gain_r);
      sdvbm_pkg::REG_BAL_LEFT:  prdata = DW'(bal_left_r);
      sdvbm_pkg::REG_BAL_RIGHT: prdata = DW'(bal_right_r);
      default:                  prdata = '0;
    endcase
  end

  // gains and balance positions
  always_comb begin
    wg    = $signed(COEF_W'(wet_gain_r));
    g     = (wg > C_ONE) ? C_ONE : wg;
    g_inv = C_ONE - g;
    vol   = $signed(COEF_W'(vol_gain_r));
    blx   = COEF_W'(bal_left_r);
    brx   = COEF_W'(bal_right_r);
    bl    = (blx > C_ONE) ? C_ONE : ((blx < -C_ONE) ? -C_ONE : blx);
    br    = (brx > C_ONE) ? C_ONE : ((brx < -C_ONE) ? -C_ONE : brx);
    pl    = bl + C_ONE;
    pr    = br + C_ONE;
  end

  always_comb begin
    lane_ctrl.step   = state_r;
    lane_ctrl.dw_en  = stage_en_r[sdvbm_pkg::STG_DRYWET] && (g != C_ONE);
    lane_ctrl.vol_en = stage_en_r[sdvbm_pkg::STG_VOLUME] && (vol != C_ONE);
    lane_ctrl.bal_en = stage_en_r[sdvbm_pkg::STG_BALANCE] && !mono_r &&
                       ((bl != -C_ONE) || (br != C_ONE));
  end

  assign in_stall   = (state_r != sdvbm_pkg::ST_IDLE);
  assign merge_load = (state_r == sdvbm_pkg::ST_MERGE) && merge_ready;

  always_comb begin
    unique case (state_r)
      sdvbm_pkg::ST_IDLE:     state_nxt = in_valid ? sdvbm_pkg::ST_MUL_WET : sdvbm_pkg::ST_IDLE;
      sdvbm_pkg::ST_MUL_WET:  state_nxt = sdvbm_pkg::ST_MUL_DRY;
      sdvbm_pkg::ST_MUL_DRY:  state_nxt = sdvbm_pkg::ST_DW_END;
      sdvbm_pkg::ST_DW_END:   state_nxt = sdvbm_pkg::ST_MUL_VOL;
      sdvbm_pkg::ST_MUL_VOL:  state_nxt = sdvbm_pkg::ST_VOL_END;
      sdvbm_pkg::ST_VOL_END:  state_nxt = sdvbm_pkg::ST_MUL_BAL0;
      sdvbm_pkg::ST_MUL_BAL0: state_nxt = sdvbm_pkg::ST_MUL_BAL1;
      sdvbm_pkg::ST_MUL_BAL1: state_nxt = sdvbm_pkg::ST_BAL_END;
      sdvbm_pkg::ST_BAL_END:  state_nxt = sdvbm_pkg::ST_MERGE;
      sdvbm_pkg::ST_MERGE:    state_nxt = merge_ready ? sdvbm_pkg::ST_IDLE : sdvbm_pkg::ST_MERGE;
      default:                state_nxt = sdvbm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdvbm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  sdvbm_lane u_lane_left (
    .clk        (clk),
    .ctrl       (lane_ctrl),
    .wet        (item_r.wet_left),
    .dry        (item_r.dry_left),
    .gain_wet   (g),
    .gain_dry   (g_inv),
    .gain_vol   (vol),
    .coef_own   (C_TWO - pl),
    .coef_other (C_TWO - pr),
    .other_val  (val_right),
    .val        (val_left)
  );

  sdvbm_lane u_lane_right (
    .clk        (clk),
    .ctrl       (lane_ctrl),
    .wet        (item_r.wet_right),
    .dry        (item_r.dry_right),
    .gain_wet   (g),
    .gain_dry   (g_inv),
    .gain_vol   (vol),
    .coef_own   (pr),
    .coef_other (pl),
    .other_val  (val_left),
    .val        (val_right)
  );

  sdvbm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (merge_load),
    .active    (active_r),
    .mono      (mono_r),
    .mix_left  (val_left),
    .mix_right (val_right),
    .dry_left  (item_r.dry_left),
    .dry_right (item_r.dry_right),
    .block_end (item_r.block_end),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ready     (merge_ready)
  );

endmodule

`default_nettype wire

// ===== sv/sdvbm_checker.sv =====
`default_nettype none

`include "stereo_drywet_volume_balance_mixer_defines.svh"

module sdvbm_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input sdvbm_pkg::out_item_t  out_data,
  input logic                  pready
);

  `SDVBM_ASSERT_IMP(a_pready_high, 1'b1, pready)

  `SDVBM_ASSERT_NXT(a_one_frame_in_flight, in_valid && !in_stall, in_stall)

  `SDVBM_ASSERT_IMP(a_peaks_quiet, out_valid && !out_data.peaks_valid, (out_data.in_peak_left == '0) && (out_data.in_peak_right == '0) && (out_data.out_peak_left == '0) && (out_data.out_peak_right == '0))

  `SDVBM_ASSERT_IMP(a_out_peak_range, out_valid, !(out_data.out_peak_left[sdvbm_pkg::SAMPLE_BITS-1] && (|out_data.out_peak_left[sdvbm_pkg::SAMPLE_BITS-2:0])))

  `SDVBM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind stereo_drywet_volume_balance_mixer sdvbm_checker u_sdvbm_checker (.*);

`default_nettype wire

// ===== bench/tb_stereo_drywet_volume_balance_mixer.sv =====
`default_nettype none

module tb_stereo_drywet_volume_balance_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import sdvbm_pkg::*;

  localparam longint UNITY = longint'(1) << GAIN_FRAC_BITS;
  localparam longint S_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint S_MIN = -S_MAX - 1;
  localparam logic [SAMPLE_BITS-1:0] PEAK_POS = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] PEAK_NEG = 24'h800000;
  localparam int MAX_WAIT = 18;
  localparam int LONG_HOLD = 400;
  localparam int RAND_FRAMES = 1300;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [31:0] val;
    in_item_t    frame;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // register mirror and peak meters of the predictor
  bit       mirror_active;
  bit [2:0] m_stages;
  bit       m_mono;
  longint   m_wet;
  longint   m_vol;
  longint   m_bal_l;
  longint   m_bal_r;
  longint   pk_in[2];
  longint   pk_out[2];

  out_item_t pending_mixes[$];
  plan_row_t plan[$];
  bit        gaps_on;
  bit        hold_req;
  int        errors;
  int        frames_sent;
  int        beats_checked;
  int        peak_beats;
  int        reg_writes;

  stereo_drywet_volume_balance_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("timeout at %0t", $time);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic out_item_t mix_frame(in_item_t f);
    longint dl, dr, wl, wr, l, r, g, bl, br, pl, pr, nl;
    out_item_t o;
    dl = f.dry_left;
    dr = f.dry_right;
    wl = f.wet_left;
    wr = f.wet_right;
    o = '0;
    l = 0;
    r = 0;
    if (absval(dl) > pk_in[0]) pk_in[0] = absval(dl);
    if (!m_mono && absval(dr) > pk_in[1]) pk_in[1] = absval(dr);
    if (mirror_active) begin
      g = (m_wet > UNITY) ? UNITY : m_wet;
      bl = clip(m_bal_l, -UNITY, UNITY);
      br = clip(m_bal_r, -UNITY, UNITY);
      l = wl;
      r = m_mono ? 0 : wr;
      if (m_stages[STG_DRYWET] && g != UNITY) begin
        l = rnd_shift(wl * g + dl * (UNITY - g), GAIN_FRAC_BITS);
        if (!m_mono) r = rnd_shift(wr * g + dr * (UNITY - g), GAIN_FRAC_BITS);
      end
      if (m_stages[STG_VOLUME] && m_vol != UNITY) begin
        l = rnd_shift(l * m_vol, GAIN_FRAC_BITS);
        r = rnd_shift(r * m_vol, GAIN_FRAC_BITS);
      end
      if (m_stages[STG_BALANCE] && !m_mono && (bl != -UNITY || br != UNITY)) begin
        pl = bl + UNITY;
        pr = br + UNITY;
        nl = rnd_shift(l * (2 * UNITY - pl) + r * (2 * UNITY - pr), GAIN_FRAC_BITS + 1);
        r = rnd_shift(r * pr + l * pl, GAIN_FRAC_BITS + 1);
        l = nl;
      end
      l = clip(l, S_MIN, S_MAX);
      r = m_mono ? 0 : clip(r, S_MIN, S_MAX);
      if (absval(l) > pk_out[0]) pk_out[0] = absval(l);
      if (absval(r) > pk_out[1]) pk_out[1] = absval(r);
    end
    o.mixed_left = l[SAMPLE_BITS-1:0];
    o.mixed_right = r[SAMPLE_BITS-1:0];
    o.peaks_valid = f.block_end;
    if (f.block_end) begin
      o.in_peak_left = pk_in[0][SAMPLE_BITS-1:0];
      o.in_peak_right = pk_in[1][SAMPLE_BITS-1:0];
      o.out_peak_left = pk_out[0][SAMPLE_BITS-1:0];
      o.out_peak_right = pk_out[1][SAMPLE_BITS-1:0];
      pk_in[0] = 0;
      pk_in[1] = 0;
      pk_out[0] = 0;
      pk_out[1] = 0;
    end
    return o;
  endfunction

  function automatic int pick_wait();
    if (!gaps_on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [31:0] s;
    s = $urandom();
    case ($urandom_range(0, 9))
      0: return PEAK_POS;
      1: return PEAK_NEG;
      2: return '0;
      3: return '1;
      4: return {{(SAMPLE_BITS - 8){s[7]}}, s[7:0]};
      default: return s[SAMPLE_BITS-1:0];
    endcase
  endfunction

  function automatic in_item_t random_frame();
    in_item_t f;
    f.dry_left = pick_sample();
    f.dry_right = pick_sample();
    f.wet_left = pick_sample();
    f.wet_right = pick_sample();
    f.block_end = ($urandom_range(0, 7) == 0);
    return f;
  endfunction

  function automatic out_item_t result(logic [23:0] ml, logic [23:0] mr, logic pv,
                                       logic [23:0] ipl, logic [23:0] ipr,
                                       logic [23:0] opl, logic [23:0] opr);
    out_item_t o;
    o.mixed_left = ml;
    o.mixed_right = mr;
    o.peaks_valid = pv;
    o.in_peak_left = ipl;
    o.in_peak_right = ipr;
    o.out_peak_left = opl;
    o.out_peak_right = opr;
    return o;
  endfunction

  function automatic plan_row_t cfg_row(reg_idx_t idx, logic [31:0] v);
    plan_row_t p;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.val = v;
    p.frame = '0;
    p.typed = 1'b0;
    p.want = '0;
    return p;
  endfunction

  function automatic plan_row_t frame_row(logic [23:0] dl, logic [23:0] dr, logic [23:0] wl,
                                          logic [23:0] wr, logic be, bit typed,
                                          out_item_t want);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.idx = REG_ACTIVE;
    p.val = '0;
    p.frame.dry_left = dl;
    p.frame.dry_right = dr;
    p.frame.wet_left = wl;
    p.frame.wet_right = wr;
    p.frame.block_end = be;
    p.typed = typed;
    p.want = want;
    return p;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ACTIVE:    mirror_active = v[0];
      REG_STAGE_EN:  m_stages = v[2:0];
      REG_MONO:      m_mono = v[0];
      REG_WET_GAIN:  m_wet = longint'(v[15:0]);
      REG_VOL_GAIN:  m_vol = longint'(v[15:0]);
      REG_BAL_LEFT:  m_bal_l = longint'($signed(v[16:0]));
      REG_BAL_RIGHT: m_bal_r = longint'($signed(v[16:0]));
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic send_frame(in_item_t f, bit typed, out_item_t want);
    int gap;
    out_item_t guess;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = mix_frame(f);
    pending_mixes.push_back(typed ? want : guess);
    frames_sent++;
  endtask

  task automatic drain();
    while (pending_mixes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_balance();
    case ($urandom_range(0, 4))
      0: return 32'h18000;
      1: return 32'h08000;
      2: return 32'h0;
      3: return ($urandom_range(0, 65536) - 32'd32768) & 32'h1FFFF;
      default: return 32'($urandom() & 32'h1FFFF);
    endcase
  endfunction

  task automatic shuffle_config(bit all);
    logic [31:0] v;
    if (all || $urandom_range(0, 2) != 0)
      write_reg(REG_ACTIVE, 32'($urandom_range(0, 4) != 0));
    if (all || $urandom_range(0, 2) != 0)
      write_reg(REG_STAGE_EN, $urandom_range(0, 7));
    if (all || $urandom_range(0, 2) != 0)
      write_reg(REG_MONO, 32'($urandom_range(0, 3) == 0));
    if (all || $urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 4))
        0: v = 0;
        1: v = 32768;
        2: v = 65535;
        3: v = $urandom_range(0, 32768);
        default: v = $urandom() & 32'hFFFF;
      endcase
      write_reg(REG_WET_GAIN, v);
    end
    if (all || $urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 32768;
        2: v = 41615;
        3: v = 65535;
        4: v = $urandom_range(0, 41615);
        default: v = $urandom() & 32'hFFFF;
      endcase
      write_reg(REG_VOL_GAIN, v);
    end
    if (all || $urandom_range(0, 2) != 0) write_reg(REG_BAL_LEFT, pick_balance());
    if (all || $urandom_range(0, 2) != 0) write_reg(REG_BAL_RIGHT, pick_balance());
  endtask

  task automatic check_field(string name, logic [SAMPLE_BITS-1:0] want,
                             logic [SAMPLE_BITS-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_mixes.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected, expected none got %h %h", $time,
                 out_data.mixed_left, out_data.mixed_right);
      end else begin
        want = pending_mixes.pop_front();
        check_field("mixed_left", want.mixed_left, out_data.mixed_left);
        check_field("mixed_right", want.mixed_right, out_data.mixed_right);
        check_field("peaks_valid", SAMPLE_BITS'(want.peaks_valid),
                    SAMPLE_BITS'(out_data.peaks_valid));
        check_field("in_peak_left", want.in_peak_left, out_data.in_peak_left);
        check_field("in_peak_right", want.in_peak_right, out_data.in_peak_right);
        check_field("out_peak_left", want.out_peak_left, out_data.out_peak_left);
        check_field("out_peak_right", want.out_peak_right, out_data.out_peak_right);
        beats_checked++;
        if (want.peaks_valid) peak_beats++;
      end
    end
  end

  // result side: random stall per beat, plus one long hold-off on request
  initial begin
    int w;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        w = pick_wait();
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int n;
    int random_sent;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    mirror_active = 1'b0;
    m_stages = '0;
    m_mono = 1'b0;
    m_wet = UNITY;
    m_vol = UNITY;
    m_bal_l = -UNITY;
    m_bal_r = UNITY;
    pk_in = '{0, 0};
    pk_out = '{0, 0};
    gaps_on = 1'b1;
    hold_req = 1'b0;
    random_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // inactive after reset: silence, input peaks still measured
    plan.push_back(frame_row(PEAK_POS, PEAK_NEG, PEAK_NEG, PEAK_POS, 1'b0, 1'b1,
                             result('0, '0, 1'b0, '0, '0, '0, '0)));
    plan.push_back(frame_row('0, '0, PEAK_POS, '0, 1'b1, 1'b1,
                             result('0, '0, 1'b1, PEAK_POS, PEAK_NEG, '0, '0)));
    plan.push_back(cfg_row(REG_ACTIVE, 32'd1));
    // no stage enabled: wet passes straight through
    plan.push_back(frame_row('0, '0, PEAK_POS, PEAK_NEG, 1'b1, 1'b1,
                             result(PEAK_POS, PEAK_NEG, 1'b1, '0, '0, PEAK_POS, PEAK_NEG)));
    plan.push_back(cfg_row(REG_STAGE_EN, 32'd7));
    plan.push_back(frame_row(24'h123456, 24'hFEDCBA, 24'h654321, 24'hABCDEF, 1'b0, 1'b0,
                             '0));
    // fully dry
    plan.push_back(cfg_row(REG_WET_GAIN, 32'd0));
    plan.push_back(frame_row(PEAK_NEG, PEAK_POS, 24'h000123, 24'hFFFFFB, 1'b1, 1'b1,
                             result(PEAK_NEG, PEAK_POS, 1'b1, PEAK_NEG, PEAK_POS,
                                    PEAK_NEG, PEAK_POS)));
    // wet gain above one is clamped
    plan.push_back(cfg_row(REG_WET_GAIN, 32'd65535));
    plan.push_back(frame_row(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 1'b0, 1'b0,
                             '0));
    plan.push_back(cfg_row(REG_WET_GAIN, 32'd16384));
    plan.push_back(frame_row(PEAK_POS, PEAK_NEG, PEAK_NEG, PEAK_POS, 1'b0, 1'b0, '0));
    plan.push_back(frame_row(24'h000001, 24'hFFFFFF, 24'h000000, 24'h000001, 1'b1, 1'b0,
                             '0));
    // volume over range saturates, then silence
    plan.push_back(cfg_row(REG_VOL_GAIN, 32'd65535));
    plan.push_back(frame_row(PEAK_POS, PEAK_NEG, PEAK_POS, PEAK_NEG, 1'b0, 1'b0, '0));
    plan.push_back(cfg_row(REG_VOL_GAIN, 32'd0));
    plan.push_back(frame_row(PEAK_POS, PEAK_NEG, PEAK_NEG, PEAK_POS, 1'b1, 1'b0, '0));
    // balance positions beyond the ends are clamped
    plan.push_back(cfg_row(REG_VOL_GAIN, 32'd41615));
    plan.push_back(cfg_row(REG_BAL_LEFT, 32'h0FFFF));
    plan.push_back(cfg_row(REG_BAL_RIGHT, 32'h10000));
    plan.push_back(frame_row(PEAK_POS, 24'h400000, PEAK_NEG, 24'h3FFFFF, 1'b0, 1'b0, '0));
    plan.push_back(frame_row(24'hFFFFFF, PEAK_POS, 24'h000001, PEAK_NEG, 1'b1, 1'b0, '0));
    plan.push_back(cfg_row(REG_BAL_LEFT, 32'd0));
    plan.push_back(cfg_row(REG_BAL_RIGHT, 32'd0));
    plan.push_back(frame_row(PEAK_POS, PEAK_POS, PEAK_NEG, PEAK_POS, 1'b0, 1'b0, '0));
    // mono: right side silent and unmetered
    plan.push_back(cfg_row(REG_MONO, 32'd1));
    plan.push_back(frame_row(PEAK_NEG, PEAK_POS, PEAK_POS, PEAK_NEG, 1'b1, 1'b0, '0));
    // inactive again
    plan.push_back(cfg_row(REG_ACTIVE, 32'd0));
    plan.push_back(frame_row(PEAK_NEG, PEAK_NEG, PEAK_POS, PEAK_POS, 1'b1, 1'b0, '0));
    plan.push_back(frame_row('0, PEAK_NEG, PEAK_POS, PEAK_POS, 1'b1, 1'b1,
                             result('0, '0, 1'b1, '0, '0, '0, '0)));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        in_valid <= 1'b0;
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_frame(plan[i].frame, plan[i].typed, plan[i].want);
      end
    end
    in_valid <= 1'b0;

    for (int ph = 0; random_sent < RAND_FRAMES; ph++) begin
      drain();
      shuffle_config(ph == 0);
      gaps_on = (ph % 4 != 1) && (ph != 2);
      // block fills while results are held back
      if (ph == 2) hold_req = 1'b1;
      n = $urandom_range(40, 110);
      repeat (n) send_frame(random_frame(), 1'b0, '0);
      random_sent += n;
      in_valid <= 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d frames over %0d register writes", frames_sent, reg_writes);
    $display("%0d beats compared, %0d of them with block peaks", beats_checked, peak_beats);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== stereo_drywet_volume_balance_mixer.f =====
+incdir+sv
sv/sdvbm_pkg.sv
sv/sdvbm_lane.sv
sv/sdvbm_merge.sv
sv/stereo_drywet_volume_balance_mixer.sv
sv/sdvbm_checker.sv
bench/tb_stereo_drywet_volume_balance_mixer.sv
